/* sv/assert_macros.svh */
// Assertion macros shared by the merge heap RTL.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define KMH_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define KMH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/kmh_pkg.sv */
// Package for the k-way merge heap: sizes, codes, node type and shared types.
// No dependencies.
package kmh_pkg;

	localparam int LISTS      = 8;
	localparam int LIST_DEPTH = 64;
	localparam int DATA_WIDTH = 32;

	localparam int LIDX_W    = $clog2(LISTS);
	localparam int LEVELS    = LIDX_W;
	localparam int LEAVES    = 1 << LEVELS;
	localparam int LEN_W     = $clog2(LIST_DEPTH + 1);
	localparam int MEM_DEPTH = LISTS * LIST_DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CNT_W     = $clog2(LISTS + 1);
	localparam int SET_W     = $clog2(LEVELS + 2);

	localparam int FUNC_W   = 2;
	localparam int IDX_W    = 3;
	localparam int STATUS_W = 2;
	localparam int SRC_W    = 3;

	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_MERGE = 2'd3;

	typedef struct packed {
		logic                         vld;
		logic signed [DATA_WIDTH-1:0] val;
		logic [LIDX_W-1:0]            lst;
	} node_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_APPEND,
		OP_CLEAR,
		OP_IGNORE,
		OP_POP_EMPTY,
		OP_BUILD_START,
		OP_BUILD_READ,
		OP_TAKE,
		OP_REFILL
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [LIDX_W-1:0] build_idx;
	} cmd_t;

	typedef struct packed {
		logic merging;
		logic any_data;
		logic take_last;
	} stat_t;

	// smaller value wins, equal values go to the lower list
	function automatic node_t pick_min(node_t a, node_t b);
		logic a_first;
		a_first = a.vld && (!b.vld || ($signed(a.val) < $signed(b.val)) ||
			((a.val == b.val) && (a.lst < b.lst)));
		return a_first ? a : b;
	endfunction

endpackage

/* sv/kmh_tree.sv */
// Registered min tree over the list heads; every level of the tree is registered.
// Depends on kmh_pkg.
module kmh_tree import kmh_pkg::*; (
	input  logic  clk,
	input  node_t leaf [LISTS],
	output node_t root
);

	node_t node_q [1:LEAVES-1];
	node_t all_n  [1:2*LEAVES-1];

	for (genvar n = 1; n < LEAVES; n++) begin : g_inner
		assign all_n[n] = node_q[n];
	end

	for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
		if (g < LISTS) begin : g_used
			assign all_n[LEAVES+g] = leaf[g];
		end else begin : g_pad
			assign all_n[LEAVES+g] = '0;
		end
	end

	always_ff @(posedge clk) begin
		for (int n = 1; n < LEAVES; n++) begin
			node_q[n] <= pick_min(all_n[2*n], all_n[2*n+1]);
		end
	end

	assign root = node_q[1];

endmodule

/* sv/kmh_dp.sv */
// Datapath of the merge heap: list memory, lengths, read positions, heads, result registers.
// Depends on kmh_pkg and kmh_tree.
module kmh_dp import kmh_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	input  logic [IDX_W-1:0]             list_index,
	input  logic signed [DATA_WIDTH-1:0] value,
	output stat_t                        st,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	output logic signed [DATA_WIDTH-1:0] out_value,
	output logic [SRC_W-1:0]             source_list,
	output logic                         last
);

	logic signed [DATA_WIDTH-1:0] mem [MEM_DEPTH];
	logic signed [DATA_WIDTH-1:0] rdata_q;

	logic [LEN_W-1:0] len_q [LISTS];
	logic [LEN_W-1:0] pos_q [LISTS];
	logic [CNT_W-1:0] count_q;
	logic             merging_q;

	logic [LISTS-1:0]             leaf_vld_q;
	logic signed [DATA_WIDTH-1:0] leaf_val_q [LISTS];
	node_t                        leaf [LISTS];
	node_t                        root;

	logic              bwr_s1;
	logic              bnz_s1;
	logic [LIDX_W-1:0] bidx_s1;
	logic [LIDX_W-1:0] rf_idx_q;
	logic              rf_has_q;

	logic                         done_q;
	logic [STATUS_W-1:0]          status_q;
	logic signed [DATA_WIDTH-1:0] out_value_q;
	logic [SRC_W-1:0]             source_list_q;
	logic                         last_q;

	logic [LIDX_W-1:0] aidx;
	logic              idx_ok;
	logic [LIDX_W-1:0] sel;
	logic [LEN_W-1:0]  len_sel;
	logic [LEN_W-1:0]  pos_sel;
	logic [LEN_W-1:0]  next_pos;
	logic [LEN_W-1:0]  tk_next;
	logic              full;
	logic              has_next;
	logic              any_data;
	logic              take_last;
	logic              wr_en;
	logic              rd_en;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	kmh_tree u_tree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	always_comb begin
		for (int i = 0; i < LISTS; i++) begin
			leaf[i].vld = leaf_vld_q[i];
			leaf[i].val = leaf_val_q[i];
			leaf[i].lst = LIDX_W'(i);
		end
	end

	always_comb begin
		any_data = 1'b0;
		for (int i = 0; i < LISTS; i++) begin
			any_data = any_data | (len_q[i] != '0);
		end
	end

	always_comb begin
		tk_next   = pos_q[root.lst] + LEN_W'(1);
		take_last = !(tk_next < len_q[root.lst]) && (count_q == CNT_W'(1));
	end

	always_comb begin
		aidx   = LIDX_W'(list_index);
		idx_ok = int'(list_index) < LISTS;
		case (cmd.op)
			OP_APPEND: sel = aidx;
			OP_TAKE:   sel = root.lst;
			default:   sel = cmd.build_idx;
		endcase
		len_sel   = len_q[sel];
		pos_sel   = pos_q[sel];
		next_pos  = pos_sel + LEN_W'(1);
		full      = !idx_ok || (len_sel >= LEN_W'(LIST_DEPTH));
		has_next  = next_pos < len_sel;
		wr_en     = (cmd.op == OP_APPEND) && !merging_q && !full;
		rd_en     = (cmd.op == OP_BUILD_READ) || (cmd.op == OP_TAKE);
		base      = ADDR_W'(sel) * ADDR_W'(LIST_DEPTH);
		waddr     = base + ADDR_W'(len_sel);
		raddr     = (cmd.op == OP_TAKE) ? base + ADDR_W'(next_pos) : base;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= value;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LISTS; i++) begin
				len_q[i] <= '0;
				pos_q[i] <= '0;
			end
			count_q    <= '0;
			merging_q  <= 1'b0;
			leaf_vld_q <= '0;
			bwr_s1     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			bwr_s1 <= 1'b0;
			if (bwr_s1) begin
				leaf_vld_q[bidx_s1] <= bnz_s1;
				count_q             <= count_q + CNT_W'(bnz_s1);
			end
			case (cmd.op)
				OP_APPEND: begin
					done_q <= 1'b1;
					if (wr_en) begin
						len_q[sel] <= len_sel + LEN_W'(1);
					end
				end
				OP_CLEAR: begin
					done_q <= 1'b1;
					for (int i = 0; i < LISTS; i++) begin
						len_q[i] <= '0;
						pos_q[i] <= '0;
					end
					count_q    <= '0;
					merging_q  <= 1'b0;
					leaf_vld_q <= '0;
				end
				OP_IGNORE, OP_POP_EMPTY: begin
					done_q <= 1'b1;
				end
				OP_BUILD_START: begin
					for (int i = 0; i < LISTS; i++) begin
						pos_q[i] <= '0;
					end
					count_q    <= '0;
					merging_q  <= 1'b1;
					leaf_vld_q <= '0;
				end
				OP_BUILD_READ: begin
					bwr_s1 <= 1'b1;
				end
				OP_TAKE: begin
					done_q <= 1'b1;
					if (take_last) begin
						for (int i = 0; i < LISTS; i++) begin
							len_q[i] <= '0;
							pos_q[i] <= '0;
						end
						count_q    <= '0;
						merging_q  <= 1'b0;
						leaf_vld_q <= '0;
					end else begin
						pos_q[sel] <= next_pos;
						if (!has_next) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				OP_REFILL: begin
					leaf_vld_q[rf_idx_q] <= rf_has_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (bwr_s1) begin
			leaf_val_q[bidx_s1] <= rdata_q;
		end
		if (cmd.op == OP_BUILD_READ) begin
			bidx_s1 <= cmd.build_idx;
			bnz_s1  <= len_sel != '0;
		end
		if (cmd.op == OP_REFILL) begin
			leaf_val_q[rf_idx_q] <= rdata_q;
		end
		status_q      <= ST_OK;
		out_value_q   <= '0;
		source_list_q <= '0;
		last_q        <= 1'b0;
		case (cmd.op)
			OP_APPEND: begin
				if (merging_q) begin
					status_q <= ST_MERGE;
				end else if (full) begin
					status_q <= ST_FULL;
				end
			end
			OP_POP_EMPTY: begin
				status_q <= ST_EMPTY;
			end
			OP_TAKE: begin
				out_value_q   <= root.val;
				source_list_q <= SRC_W'(root.lst);
				last_q        <= take_last;
				rf_idx_q      <= root.lst;
				rf_has_q      <= has_next;
			end
			default: begin
			end
		endcase
	end

	assign st.merging   = merging_q;
	assign st.any_data  = any_data;
	assign st.take_last = take_last;

	assign done        = done_q;
	assign status      = status_q;
	assign out_value   = out_value_q;
	assign source_list = source_list_q;
	assign last        = last_q;

endmodule

/* sv/kmh_ctrl.sv */
// Controller of the merge heap: sequences head loading, tree settling, take and refill.
// Depends on kmh_pkg.
module kmh_ctrl import kmh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [FUNC_W-1:0] func,
	input  stat_t             st,
	output cmd_t              cmd,
	output logic              busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BUILD,
		S_SETTLE,
		S_TAKE,
		S_REFILL
	} state_t;

	state_t            state_q, state_d;
	logic [LIDX_W-1:0] bcnt_q, bcnt_d;
	logic [SET_W-1:0]  scnt_q, scnt_d;
	logic              to_take_q, to_take_d;
	logic              busy_q;

	always_comb begin
		state_d       = state_q;
		bcnt_d        = bcnt_q;
		scnt_d        = scnt_q;
		to_take_d     = to_take_q;
		cmd.op        = OP_NONE;
		cmd.build_idx = bcnt_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (func)
						FUNC_APPEND: cmd.op = OP_APPEND;
						FUNC_CLEAR:  cmd.op = OP_CLEAR;
						FUNC_POP: begin
							if (st.merging) begin
								state_d = S_TAKE;
							end else if (st.any_data) begin
								cmd.op  = OP_BUILD_START;
								state_d = S_BUILD;
								bcnt_d  = '0;
							end else begin
								cmd.op = OP_POP_EMPTY;
							end
						end
						default: cmd.op = OP_IGNORE;
					endcase
				end
			end
			S_BUILD: begin
				cmd.op = OP_BUILD_READ;
				if (bcnt_q == LIDX_W'(LISTS - 1)) begin
					state_d   = S_SETTLE;
					scnt_d    = SET_W'(LEVELS + 1);
					to_take_d = 1'b1;
				end else begin
					bcnt_d = bcnt_q + LIDX_W'(1);
				end
			end
			S_SETTLE: begin
				if (scnt_q == SET_W'(1)) begin
					state_d = to_take_q ? S_TAKE : S_IDLE;
				end else begin
					scnt_d = scnt_q - SET_W'(1);
				end
			end
			S_TAKE: begin
				cmd.op  = OP_TAKE;
				state_d = st.take_last ? S_IDLE : S_REFILL;
			end
			S_REFILL: begin
				cmd.op    = OP_REFILL;
				state_d   = S_SETTLE;
				scnt_d    = SET_W'(LEVELS);
				to_take_d = 1'b0;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bcnt_q    <= '0;
			scnt_q    <= '0;
			to_take_q <= 1'b0;
			busy_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			bcnt_q    <= bcnt_d;
			scnt_q    <= scnt_d;
			to_take_q <= to_take_d;
			busy_q    <= state_d != S_IDLE;
		end
	end

	assign busy = busy_q;

endmodule

/* sv/k_way_merge_heap_top.sv */
// Top level of the k-way merge heap: controller, datapath and checks.
// Depends on kmh_pkg, kmh_ctrl, kmh_dp and assert_macros.svh.
//
// channel   handshake           payload
// command   start & !busy       func, list_index, value
// result    done (one cycle)    status, out_value, source_list, last
//
// Append, clear, unused codes, pop with nothing left: result the cycle after the transaction,
// busy stays low. Pop during a merge: result once the controller has entered its take state
// and registered done, busy while the head is taken, refilled and the registered min tree
// settles, busy only while the head is taken when the pop ends the merge.
// The first pop of a merge loads one list head a cycle from the single read port of the
// list memory, then the tree settles and the head is taken. The result side cannot stall.
`include "assert_macros.svh"

module k_way_merge_heap_top import kmh_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [FUNC_W-1:0]            func,
	input  logic [IDX_W-1:0]             list_index,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         busy,
	output logic                         done,
	output logic [STATUS_W-1:0]          status,
	output logic signed [DATA_WIDTH-1:0] out_value,
	output logic [SRC_W-1:0]             source_list,
	output logic                         last
);

	cmd_t  cmd;
	stat_t st;

	kmh_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	kmh_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.list_index  (list_index),
		.value       (value),
		.st          (st),
		.done        (done),
		.status      (status),
		.out_value   (out_value),
		.source_list (source_list),
		.last        (last)
	);

	`KMH_ASSERT_NEXT(a_quick_done, start && !busy && func != FUNC_POP, done, "no result")
	`KMH_ASSERT_IMPL(a_last_ok, done && last, status == ST_OK, "last flagged on a failed result")
	`KMH_ASSERT_IMPL(a_fail_zero, done && status != ST_OK, {out_value, source_list} == '0, "fail data")

endmodule
